// ===== sv/assert_macros.svh =====
// assertion helpers included by the key expansion rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define AKX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// overlapping implication checked outside reset
`define AKX_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define AKX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/akx_pkg.sv =====
package akx_pkg;

	typedef logic [31:0] word_t;
	typedef logic [3:0] round_t;

	localparam int WordCount = 4;
	localparam round_t LAST_ROUND = 4'd10;

	// aes forward s-box
	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	// round constant used to build the round after round idx
	function automatic logic [7:0] rcon(input round_t idx);
		logic [7:0] r;
		case (idx)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			4'd7: r = 8'h80;
			4'd8: r = 8'h1b;
			4'd9: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/akx_sub_word.sv =====
module akx_sub_word (
	input  akx_pkg::word_t  word,
	input  akx_pkg::round_t round_idx,
	output akx_pkg::word_t  mixed
);
	import akx_pkg::*;

	word_t rot;
	word_t sub;

	// rotate left one byte, then s-box each byte
	always_comb begin
		rot = {word[23:0], word[31:24]};
		for (int b = 0; b < 4; b++) begin
			sub[8*b +: 8] = SBOX[rot[8*b +: 8]];
		end
	end

	// round constant into the top byte
	assign mixed = sub ^ {rcon(round_idx), 24'h000000};

endmodule

// ===== sv/akx_word_cell.sv =====
module akx_word_cell (
	input  logic           clk,
	input  logic           load,
	input  akx_pkg::word_t load_word,
	input  logic           step,
	input  akx_pkg::word_t prev_word,
	output akx_pkg::word_t word,
	output akx_pkg::word_t next_word
);
	import akx_pkg::*;

	word_t word_q;

	// this word of the next round, chained from the left neighbor
	assign next_word = word_q ^ prev_word;
	assign word = word_q;

	// hold one word of the current round key
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end else if (step) begin
			word_q <= next_word;
		end
	end

endmodule

// ===== sv/aes128_key_expansion.sv =====
// AES-128 key expansion. Each accepted key request yields eleven round keys, round 0 (the
// key itself) first, one per cycle while round_key_ready stays high; last_round marks
// round 10. Four word cells hold the current round key and step it to the next round each
// time a round key moves into the output register, so a key occupies the block until its
// round 10 leaves the cells, and the next key is accepted in that same cycle; a new key is
// never taken while an earlier one is still being expanded. The output register decouples the
// two sides, so round_key_ready only gates the steps and never drops a round key.
module aes128_key_expansion (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                key_valid,
	output logic                key_ready,
	input  logic [63:0]         key_high,
	input  logic [63:0]         key_low,
	output logic                round_key_valid,
	input  logic                round_key_ready,
	output logic [63:0]         round_key_high,
	output logic [63:0]         round_key_low,
	output akx_pkg::round_t     round_number,
	output logic                last_round
);
	import akx_pkg::*;
	`include "assert_macros.svh"

	logic   busy_q;
	round_t rnd_q;
	logic   out_valid_q;
	logic   move;
	logic   accept;
	logic   at_last;
	word_t  mix;
	word_t  cur_word  [WordCount];
	word_t  next_word [WordCount];
	word_t  prev_word [WordCount];
	word_t  load_word [WordCount];

	// handshake control
	assign at_last   = (rnd_q == LAST_ROUND);
	assign move      = busy_q && (!out_valid_q || round_key_ready);
	assign key_ready = !busy_q || (move && at_last);
	assign accept    = key_valid && key_ready;

	assign load_word[0] = key_high[63:32];
	assign load_word[1] = key_high[31:0];
	assign load_word[2] = key_low[63:32];
	assign load_word[3] = key_low[31:0];

	// rotword, subword and round constant on the last word
	akx_sub_word u_sub (
		.word      (cur_word[WordCount-1]),
		.round_idx (rnd_q),
		.mixed     (mix)
	);

	// row of word cells, each xor-chained from its left neighbor
	assign prev_word[0] = mix;
	for (genvar k = 0; k < WordCount; k++) begin : g_cell
		if (k > 0) begin : g_link
			assign prev_word[k] = next_word[k-1];
		end
		akx_word_cell u_cell (
			.clk       (clk),
			.load      (accept),
			.load_word (load_word[k]),
			.step      (move),
			.prev_word (prev_word[k]),
			.word      (cur_word[k]),
			.next_word (next_word[k])
		);
	end

	// round counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			rnd_q  <= '0;
		end else if (move) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				rnd_q <= 4'(rnd_q + 4'd1);
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (round_key_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (move) begin
			round_key_high <= {cur_word[0], cur_word[1]};
			round_key_low  <= {cur_word[2], cur_word[3]};
			round_number   <= rnd_q;
			last_round     <= at_last;
		end
	end

	assign round_key_valid = out_valid_q;

	`AKX_ASSERT_IMP(a_last_flag, round_key_valid, last_round == (round_number == LAST_ROUND), "last_round disagrees with round_number")
	`AKX_ASSERT_NEXT(a_accept_starts, accept, busy_q && rnd_q == 4'd0, "accepted key did not start at round 0")
	`AKX_ASSERT_IMP(a_rnd_range, busy_q, rnd_q <= LAST_ROUND, "round counter out of range")
	`AKX_ASSERT_NEXT(a_done_frees, move && at_last && !accept, !busy_q, "block stayed busy after round 10")

endmodule
